>>> rtl/core/iawp_pkg.sv
`timescale 1ns / 1ps
package iawp_pkg;

	typedef struct packed {
		logic [30:0] operand_a;
		logic [30:0] operand_b;
		logic [2:0]  opcode;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               divide_by_zero;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4,
		OP_POW = 3'd5
	} opcode_t;

	// operation class decided by the front end
	typedef enum logic [2:0] {
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_REM,
		K_POW,
		K_ZERO
	} kind_t;

	typedef struct packed {
		logic [30:0] a;
		logic [30:0] b;
		kind_t       kind;
		logic        dz;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_POW,
		ST_DONE
	} back_state_t;

endpackage

>>> rtl/core/iawp_front.sv
`timescale 1ns / 1ps
module iawp_front #(
	parameter int DATA_WIDTH = 32
) (
	input  iawp_pkg::in_item_t item,
	output iawp_pkg::job_t     job
);
	import iawp_pkg::*;

	localparam int OW = (DATA_WIDTH < 31) ? DATA_WIDTH : 31;

	logic [30:0] a_t;
	logic [30:0] b_t;
	kind_t       kind;

	// operands are truncated to OW = min(DATA_WIDTH, 31) bits before any use
	assign a_t = 31'(item.operand_a[OW-1:0]);
	assign b_t = 31'(item.operand_b[OW-1:0]);

	always_comb begin
		unique case (item.opcode)
			OP_ADD:  kind = K_ADD;
			OP_SUB:  kind = K_SUB;
			OP_MUL:  kind = K_MUL;
			OP_DIV:  kind = K_DIV;
			OP_REM:  kind = K_REM;
			OP_POW:  kind = K_POW;
			default: kind = K_ZERO;
		endcase
	end

	always_comb begin
		job.a    = a_t;
		job.b    = b_t;
		job.dz   = ((kind == K_DIV) || (kind == K_REM)) && (b_t == '0);
		job.kind = job.dz ? K_ZERO : kind;
	end

endmodule

>>> rtl/core/iawp_queue.sv
`timescale 1ns / 1ps
module iawp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  iawp_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd,
	output iawp_pkg::job_t rd_job,
	output logic           empty
);
	import iawp_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

>>> rtl/core/iawp_back.sv
`timescale 1ns / 1ps
module iawp_back #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iawp_pkg::job_t       job,
	input  logic                 job_empty,
	output logic                 job_pop,
	output iawp_pkg::out_item_t  res,
	output logic                 empty,
	input  logic                 pop
);
	import iawp_pkg::*;

	localparam int RW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int OW = (DATA_WIDTH < 31) ? DATA_WIDTH : 31;
	localparam int CW = $clog2(OW);

	back_state_t      state_q;
	back_state_t      state_d;
	kind_t            kind_q;
	logic             dz_q;
	logic [RW-1:0]    acc_q;
	logic [RW-1:0]    base_q;
	logic [OW-1:0]    exp_q;
	logic [OW-1:0]    quo_q;
	logic [OW-1:0]    rem_q;
	logic [CW-1:0]    cnt_q;
	logic             sq_phase_q;
	logic [RW-1:0]    res_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [2*RW-1:0]  prod;
	logic [RW-1:0]    mul_x;
	logic [OW:0]      trial;
	logic             fits;
	logic             take_job;
	logic             load_out;

	// one shared multiplier; square step uses base on both sides
	assign mul_x = (state_q == ST_POW && sq_phase_q) ? base_q : acc_q;
	assign prod  = mul_x * base_q;

	// restoring divide: one quotient bit per cycle
	assign trial = {rem_q, quo_q[OW-1]};
	assign fits  = (trial >= {1'b0, exp_q});

	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = job_empty ? ST_IDLE :
				(job.kind == K_MUL) ? ST_MUL :
				((job.kind == K_DIV) || (job.kind == K_REM)) ? ST_DIV :
				(job.kind == K_POW) ? ST_POW : ST_DONE;
			ST_MUL:  state_d = ST_DONE;
			ST_DIV:  state_d = (cnt_q == CW'(OW - 1)) ? ST_DONE : ST_DIV;
			ST_POW:  state_d = (exp_q == '0) ? ST_DONE : ST_POW;
			ST_DONE: state_d = (!out_valid_q || pop) ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take_job = (state_q == ST_IDLE) && !job_empty;
		load_out = (state_q == ST_DONE) && (!out_valid_q || pop);
		job_pop  = take_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q     <= job.kind;
				dz_q       <= job.dz;
				cnt_q      <= '0;
				sq_phase_q <= 1'b0;
				rem_q      <= '0;
				quo_q      <= job.a[OW-1:0];
				exp_q      <= job.b[OW-1:0];
				case (job.kind)
					K_ADD: res_q <= RW'(job.a) + RW'(job.b);
					K_SUB: res_q <= RW'(job.a) - RW'(job.b);
					default: res_q <= '0;
				endcase
				if (job.kind == K_POW) begin
					acc_q  <= RW'(1);
				end else begin
					acc_q  <= RW'(job.a);
				end
				base_q <= (job.kind == K_POW) ? RW'(job.a) : RW'(job.b);
			end
			ST_MUL: res_q <= prod[RW-1:0];
			ST_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				quo_q <= {quo_q[OW-2:0], fits};
				rem_q <= fits ? OW'(trial - {1'b0, exp_q}) : trial[OW-1:0];
				if (cnt_q == CW'(OW - 1)) begin
					res_q <= (kind_q == K_DIV) ? RW'({quo_q[OW-2:0], fits})
						: RW'(fits ? OW'(trial - {1'b0, exp_q}) : trial[OW-1:0]);
				end
			end
			ST_POW: begin
				if (exp_q == '0) begin
					res_q <= acc_q;
				end else if (!sq_phase_q) begin
					if (exp_q[0]) acc_q <= prod[RW-1:0];
					sq_phase_q <= 1'b1;
				end else begin
					base_q     <= prod[RW-1:0];
					exp_q      <= exp_q >> 1;
					sq_phase_q <= 1'b0;
				end
			end
			default: ;
		endcase
		if (load_out) begin
			out_q.result         <= 32'(res_q);
			out_q.divide_by_zero <= dz_q;
		end
	end

	assign res   = out_q;
	assign empty = !out_valid_q;

endmodule

>>> rtl/core/integer_alu_with_power.sv
`timescale 1ns / 1ps
// Integer ALU: add, subtract, multiply, divide, remainder and power of two
// non-negative operands, result wrapped to min(DATA_WIDTH, 32) bits and shown as 32.
// Input side is a queue: drive item and push; the transaction is taken at a
// clock edge with push high and full low. A two-entry job queue sits after
// the decode front end, so a few items can be pushed while one executes.
// Result side is a one-entry register: while empty is low, res holds the result;
// pop takes it. While pop stays low the result register holds and the
// execution unit waits with its finished value, then the job queue fills
// and full rises.
// In the execution unit, add, subtract and unused codes go from idle straight
// to done; multiply passes through the multiply state; divide and remainder
// run the one-bit-per-cycle restoring divider over OW = min(DATA_WIDTH, 31)
// bits; power alternates multiply and square steps on the single shared
// multiplier used once per cycle, until the exponent is zero.
// Divide or remainder by zero returns 0 with divide_by_zero set.
// Reset empties the queue and marks the result register empty; nothing is pending after.
module integer_alu_with_power #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iawp_pkg::in_item_t  item,
	input  logic                push,
	output logic                full,
	output iawp_pkg::out_item_t res,
	output logic                empty,
	input  logic                pop
);
	import iawp_pkg::*;

	job_t job_in;
	job_t job_out;
	logic job_empty;
	logic job_pop;

	iawp_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.item (item),
		.job  (job_in)
	);

	iawp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wr_job (job_in),
		.full   (full),
		.rd     (job_pop),
		.rd_job (job_out),
		.empty  (job_empty)
	);

	iawp_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res       (res),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

>>> tb/integer_alu_with_power_tb.sv
`timescale 1ns / 1ps
module integer_alu_with_power_tb;
	import iawp_pkg::*;

	logic      clk;
	logic      arst_n;
	in_item_t  item;
	logic      push;
	logic      full;
	out_item_t res;
	logic      empty;
	logic      pop;

	out_item_t results_due[$];
	int        mismatches;
	bit        rx_stall_mode;

	integer_alu_with_power i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.push  (push),
		.full  (full),
		.res   (res),
		.empty (empty),
		.pop   (pop)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [31:0] wrapped_power(logic [31:0] base, logic [30:0] exponent);
		logic [31:0] acc;
		logic [30:0] e;
		acc = 32'd1;
		e = exponent;
		while (e != 0) begin
			if (e[0])
				acc = acc * base;
			base = base * base;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic out_item_t alu_outcome(in_item_t t);
		out_item_t   o;
		logic [31:0] a;
		logic [31:0] b;
		a = {1'b0, t.operand_a};
		b = {1'b0, t.operand_b};
		o.result = '0;
		o.divide_by_zero = 1'b0;
		case (t.opcode)
			OP_ADD: o.result = a + b;
			OP_SUB: o.result = a - b;
			OP_MUL: o.result = a * b;
			OP_DIV: begin
				if (b == 0) o.divide_by_zero = 1'b1;
				else o.result = a / b;
			end
			OP_REM: begin
				if (b == 0) o.divide_by_zero = 1'b1;
				else o.result = a % b;
			end
			OP_POW: o.result = wrapped_power(a, t.operand_b);
			default: ;
		endcase
		return o;
	endfunction

	// sender: pushes one transaction and waits for acceptance
	task automatic send_op(logic [30:0] a, logic [30:0] b, logic [2:0] op);
		in_item_t t;
		t.operand_a = a;
		t.operand_b = b;
		t.opcode = op;
		item <= t;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		results_due.push_back(alu_outcome(t));
	endtask

	// burst of random length, then a random gap
	task automatic bursty_gap(ref int burst_left);
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [30:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'h7FFFFFFF;
			2: return 31'($urandom_range(0, 15));
			3: return 31'd1 << $urandom_range(0, 30);
			default: return 31'($urandom());
		endcase
	endfunction

	task automatic test_directed();
		send_op(31'h7FFFFFFF, 31'h7FFFFFFF, OP_ADD);
		send_op(31'd0, 31'h7FFFFFFF, OP_SUB);
		send_op(31'h7FFFFFFF, 31'd0, OP_SUB);
		send_op(31'h7FFFFFFF, 31'h7FFFFFFF, OP_MUL);
		send_op(31'h7FFFFFFF, 31'd7, OP_DIV);
		send_op(31'd5, 31'd0, OP_DIV);
		send_op(31'd5, 31'd0, OP_REM);
		send_op(31'h7FFFFFFF, 31'd10, OP_REM);
		send_op(31'd0, 31'd0, OP_POW);
		send_op(31'd3, 31'd0, OP_POW);
		send_op(31'd2, 31'd31, OP_POW);
		send_op(31'h7FFFFFFF, 31'h7FFFFFFF, OP_POW);
		send_op(31'd3, 31'd20, OP_POW);
		send_op(31'h55555555, 31'h2AAAAAAA, 3'd6);
		send_op(31'h7FFFFFFF, 31'h7FFFFFFF, 3'd7);
		send_op(31'd0, 31'd1, OP_DIV);
		drain();
	endtask

	task automatic test_random(int count);
		int burst_left;
		logic [2:0] op;
		logic [30:0] b;
		burst_left = 1;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			b = rand_operand();
			// long exponents are slow; keep most powers short
			if (op == OP_POW && $urandom_range(0, 7) != 0)
				b = 31'($urandom_range(0, 40));
			send_op(rand_operand(), b, op);
			// one pause until everything has come back
			if (i == count / 2) begin
				push <= 1'b0;
				while (results_due.size() != 0) @(posedge clk);
			end
			bursty_gap(burst_left);
		end
		drain();
	endtask

	// receiver: pop pattern switches between steady popping and choppy stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_stall_mode <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0)
				rx_stall_mode <= ~rx_stall_mode;
			pop <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t exp_res;
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: result %h dz %b",
						res.result, res.divide_by_zero);
			end else begin
				exp_res = results_due.pop_front();
				if (res.result !== exp_res.result
						|| res.divide_by_zero !== exp_res.divide_by_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h dz %b, got %h dz %b",
							exp_res.result, exp_res.divide_by_zero,
							res.result, res.divide_by_zero);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1900);
		if (mismatches == 0 && results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
